// ===== design/ppe_pkg.sv =====
// ----------------------------------------------------------------------------
// ppe_pkg
// Shared types, constants and helpers for the particle pool engine.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int POOL_SIZE_DEF = 64;
  localparam int TWO_PI_Q16    = 411775;    // 2*pi in Q16.16
  localparam int HUNDREDTH_Q32 = 42949673;  // 0.01 in Q0.32
  localparam int CFG_IDX_W     = 2;
  localparam int SIZE_MAX      = 16777215;

  localparam logic [1:0] KIND_EMIT   = 2'd0;
  localparam logic [1:0] KIND_TICK   = 2'd1;
  localparam logic [1:0] KIND_RENDER = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_JIT_VEL_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_JIT_VEL_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JIT_SIZE  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] start_x;
    logic [31:0] start_y;
    logic [31:0] speed_x;
    logic [31:0] speed_y;
    logic [31:0] hue_begin;
    logic [31:0] hue_end;
    logic [23:0] extent_begin;
    logic [23:0] extent_end;
    logic [23:0] lifespan;
    logic [23:0] time_step;
    logic [63:0] random_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] draw_x;
    logic [31:0] draw_y;
    logic [23:0] draw_size;
    logic [31:0] draw_angle;
    logic [31:0] draw_color;
    logic        last;
  } out_item_t;

  // one pool slot as held in the slot memory
  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] vel_x;
    logic [31:0] vel_y;
    logic [31:0] angle;
    logic [23:0] size_begin;
    logic [23:0] size_end;
    logic [31:0] color_begin;
    logic [31:0] color_end;
    logic [23:0] life_total;
    logic [24:0] life_left;
  } slot_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_EMIT_MUL,
    ST_EMIT_WR,
    ST_SCAN,
    ST_TICK_MUL,
    ST_TICK_WR,
    ST_DIV_INIT,
    ST_DIV,
    ST_LERP_MUL,
    ST_ALPHA,
    ST_OUT
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [41:0] x);
    if (x > 42'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (x < -42'sd2147483648) begin
      return 32'h8000_0000;
    end
    return x[31:0];
  endfunction

endpackage

// ===== design/ppe_ram.sv =====
// ----------------------------------------------------------------------------
// ppe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ppe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/particle_pool_engine.sv =====
// Emit: after acceptance the item passes dispatch, the jitter multiply and the slot write before ready returns.
// Tick: the scan steps over empty slots; each live slot is read and written back with new position, angle
//   and life (one RMW through the slot RAM), and a slot whose life has run out is retired without a write.
// Render: the scan steps over empty slots; each live slot may pass the 4-bit-per-cycle life-fraction divider,
//   then the lerp multiply, alpha and output steps, and waits on any output stall; one item in flight at a time.
// Reset clears live flags and jitter registers and sets the emit pointer to the last slot; slot RAM is not cleared.
// ----------------------------------------------------------------------------
// particle_pool_engine
// Particle pool: emit into a ring of slots, tick-update and render live slots.
// ----------------------------------------------------------------------------
module particle_pool_engine #(
  parameter int POOL_SIZE = ppe_pkg::POOL_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ppe_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ppe_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ppe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [23:0]                     cfg_data
);

  localparam int AW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int SW = $bits(ppe_pkg::slot_t);

  ppe_pkg::state_t    state_r, state_nxt;
  ppe_pkg::in_item_t  in_r, in_nxt;
  ppe_pkg::slot_t     slot_r, slot_nxt;
  ppe_pkg::out_item_t out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [23:0]        jit_vx_r, jit_vx_nxt, jit_vy_r, jit_vy_nxt, jit_sz_r, jit_sz_nxt;
  logic [POOL_SIZE-1:0] alive_r, alive_nxt;
  logic [AW-1:0]      next_slot_r, next_slot_nxt;
  logic [AW:0]        idx_r, idx_nxt;
  logic [31:0]        dang_r, dang_nxt;
  logic signed [41:0] em_jx_r, em_jx_nxt, em_jy_r, em_jy_nxt, em_js_r, em_js_nxt;
  logic [34:0]        em_ang_r, em_ang_nxt;
  logic signed [55:0] prod_x_r, prod_x_nxt, prod_y_r, prod_y_nxt;
  logic [16:0]        f_r, f_nxt;
  logic [23:0]        rem_r, rem_nxt;
  logic [15:0]        quo_r, quo_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic signed [42:0] prod_sz_r, prod_sz_nxt;
  logic signed [26:0] prod_ch_r [4];
  logic signed [26:0] prod_ch_nxt [4];
  logic [23:0]        size_res_r, size_res_nxt;
  logic [23:0]        rgb_r, rgb_nxt;
  logic [25:0]        alpha_prod_r, alpha_prod_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  ppe_pkg::slot_t     ram_wdata, ram_rdata;
  logic [SW-1:0]      ram_rdata_raw;

  ppe_ram #(.WIDTH(SW), .DEPTH(POOL_SIZE)) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );
  assign ram_rdata = ppe_pkg::slot_t'(ram_rdata_raw);

  assign in_ready  = (state_r == ppe_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic signed [16:0] rj1, rj2, rj3;
    logic signed [41:0] sb;
    logic signed [17:0] fs;
    logic [49:0]        dprod;
    logic [24:0]        t;
    logic [23:0]        rem_v;
    logic [15:0]        q_v;
    logic signed [42:0] sz_v;
    logic signed [26:0] ch_v;
    logic [7:0]         e_c, b_c;
    ppe_pkg::slot_t     w;

    state_nxt      = state_r;
    in_nxt         = in_r;
    slot_nxt       = slot_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    jit_vx_nxt     = jit_vx_r;
    jit_vy_nxt     = jit_vy_r;
    jit_sz_nxt     = jit_sz_r;
    alive_nxt      = alive_r;
    next_slot_nxt  = next_slot_r;
    idx_nxt        = idx_r;
    dang_nxt       = dang_r;
    em_jx_nxt      = em_jx_r;
    em_jy_nxt      = em_jy_r;
    em_js_nxt      = em_js_r;
    em_ang_nxt     = em_ang_r;
    prod_x_nxt     = prod_x_r;
    prod_y_nxt     = prod_y_r;
    f_nxt          = f_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    cnt_nxt        = cnt_r;
    prod_sz_nxt    = prod_sz_r;
    prod_ch_nxt    = prod_ch_r;
    size_res_nxt   = size_res_r;
    rgb_nxt        = rgb_r;
    alpha_prod_nxt = alpha_prod_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r[AW-1:0];
    ram_raddr      = idx_r[AW-1:0];
    ram_wdata      = slot_r;
    w              = slot_r;
    rj1 = '0; rj2 = '0; rj3 = '0; sb = '0; fs = '0; dprod = '0;
    t = '0; rem_v = '0; q_v = '0; sz_v = '0; ch_v = '0; e_c = '0; b_c = '0;

    if (cfg_valid) begin
      case (cfg_index)
        ppe_pkg::CFG_JIT_VEL_X: jit_vx_nxt = cfg_data;
        ppe_pkg::CFG_JIT_VEL_Y: jit_vy_nxt = cfg_data;
        ppe_pkg::CFG_JIT_SIZE:  jit_sz_nxt = cfg_data;
        default: ;
      endcase
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ppe_pkg::ST_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = ppe_pkg::ST_DISPATCH;
        end
      end
      ppe_pkg::ST_DISPATCH: begin
        idx_nxt  = '0;
        dprod    = 50'(in_r.time_step) * 50'(ppe_pkg::HUNDREDTH_Q32);
        dang_nxt = 32'(dprod[49:32]);
        case (in_r.kind)
          ppe_pkg::KIND_EMIT:   state_nxt = ppe_pkg::ST_EMIT_MUL;
          ppe_pkg::KIND_TICK:   state_nxt = ppe_pkg::ST_SCAN;
          ppe_pkg::KIND_RENDER: state_nxt = ppe_pkg::ST_SCAN;
          default:              state_nxt = ppe_pkg::ST_IDLE;
        endcase
      end
      ppe_pkg::ST_EMIT_MUL: begin
        rj1 = 17'($signed({1'b0, in_r.random_word[31:16]}) - 17'sd32768);
        rj2 = 17'($signed({1'b0, in_r.random_word[47:32]}) - 17'sd32768);
        rj3 = 17'($signed({1'b0, in_r.random_word[63:48]}) - 17'sd32768);
        em_jx_nxt  = 42'($signed({1'b0, jit_vx_r}) * rj1);
        em_jy_nxt  = 42'($signed({1'b0, jit_vy_r}) * rj2);
        em_js_nxt  = 42'($signed({1'b0, jit_sz_r}) * rj3);
        em_ang_nxt = 35'(in_r.random_word[15:0]) * 35'(ppe_pkg::TWO_PI_Q16);
        state_nxt  = ppe_pkg::ST_EMIT_WR;
      end
      ppe_pkg::ST_EMIT_WR: begin
        w.pos_x       = in_r.start_x;
        w.pos_y       = in_r.start_y;
        w.vel_x       = ppe_pkg::sat32(42'($signed(in_r.speed_x)) + (em_jx_r >>> 16));
        w.vel_y       = ppe_pkg::sat32(42'($signed(in_r.speed_y)) + (em_jy_r >>> 16));
        w.angle       = 32'(em_ang_r[34:16]);
        sb            = $signed({18'b0, in_r.extent_begin}) + (em_js_r >>> 16);
        if (sb < 0) begin
          w.size_begin = '0;
        end else if (sb > 42'sd16777215) begin
          w.size_begin = 24'(ppe_pkg::SIZE_MAX);
        end else begin
          w.size_begin = sb[23:0];
        end
        w.size_end    = in_r.extent_end;
        w.color_begin = in_r.hue_begin;
        w.color_end   = in_r.hue_end;
        w.life_total  = in_r.lifespan;
        w.life_left   = {1'b0, in_r.lifespan};
        ram_we        = 1'b1;
        ram_waddr     = next_slot_r;
        ram_wdata     = w;
        alive_nxt[next_slot_r] = 1'b1;
        next_slot_nxt = (next_slot_r == '0) ? AW'(POOL_SIZE - 1) : next_slot_r - 1'b1;
        state_nxt     = ppe_pkg::ST_IDLE;
      end
      ppe_pkg::ST_SCAN: begin
        if (idx_r == (AW+1)'(POOL_SIZE)) begin
          state_nxt = ppe_pkg::ST_IDLE;
        end else if (alive_r[idx_r[AW-1:0]]) begin
          state_nxt = (in_r.kind == ppe_pkg::KIND_TICK) ? ppe_pkg::ST_TICK_MUL
                                                         : ppe_pkg::ST_DIV_INIT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ppe_pkg::ST_TICK_MUL: begin
        slot_nxt = ram_rdata;
        if ($signed(ram_rdata.life_left) <= 25'sd0) begin
          alive_nxt[idx_r[AW-1:0]] = 1'b0;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ppe_pkg::ST_SCAN;
        end else begin
          prod_x_nxt = 56'($signed(ram_rdata.vel_x) * $signed({1'b0, in_r.time_step}));
          prod_y_nxt = 56'($signed(ram_rdata.vel_y) * $signed({1'b0, in_r.time_step}));
          state_nxt  = ppe_pkg::ST_TICK_WR;
        end
      end
      ppe_pkg::ST_TICK_WR: begin
        w.life_left = 25'($signed(slot_r.life_left) - $signed({1'b0, in_r.time_step}));
        w.pos_x     = ppe_pkg::sat32(42'($signed(slot_r.pos_x)) + 42'(prod_x_r >>> 16));
        w.pos_y     = ppe_pkg::sat32(42'($signed(slot_r.pos_y)) + 42'(prod_y_r >>> 16));
        w.angle     = slot_r.angle + dang_r;
        ram_we      = 1'b1;
        ram_wdata   = w;
        idx_nxt     = idx_r + 1'b1;
        state_nxt   = ppe_pkg::ST_SCAN;
      end
      ppe_pkg::ST_DIV_INIT: begin
        slot_nxt = ram_rdata;
        if ($signed(ram_rdata.life_left) <= 25'sd0 || ram_rdata.life_total == '0) begin
          f_nxt     = '0;
          state_nxt = ppe_pkg::ST_LERP_MUL;
        end else if (ram_rdata.life_left[23:0] >= ram_rdata.life_total) begin
          f_nxt     = 17'h10000;
          state_nxt = ppe_pkg::ST_LERP_MUL;
        end else begin
          rem_nxt   = ram_rdata.life_left[23:0];
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ppe_pkg::ST_DIV;
        end
      end
      ppe_pkg::ST_DIV: begin
        // restoring division, four quotient bits a cycle; remainder stays below total
        rem_v = rem_r;
        q_v   = quo_r;
        for (int k = 0; k < 4; k++) begin
          t = {rem_v, 1'b0};
          if (t >= {1'b0, slot_r.life_total}) begin
            rem_v = 24'(t - {1'b0, slot_r.life_total});
            q_v   = {q_v[14:0], 1'b1};
          end else begin
            rem_v = t[23:0];
            q_v   = {q_v[14:0], 1'b0};
          end
        end
        rem_nxt = rem_v;
        quo_nxt = q_v;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 2'd3) begin
          f_nxt     = {1'b0, q_v};
          state_nxt = ppe_pkg::ST_LERP_MUL;
        end
      end
      ppe_pkg::ST_LERP_MUL: begin
        fs          = $signed({1'b0, f_r});
        prod_sz_nxt = 43'(($signed({1'b0, slot_r.size_begin}) -
                           $signed({1'b0, slot_r.size_end})) * fs);
        for (int c = 0; c < 4; c++) begin
          b_c = slot_r.color_begin[24-8*c +: 8];
          e_c = slot_r.color_end[24-8*c +: 8];
          prod_ch_nxt[c] = 27'(($signed({1'b0, b_c}) - $signed({1'b0, e_c})) * fs);
        end
        state_nxt = ppe_pkg::ST_ALPHA;
      end
      ppe_pkg::ST_ALPHA: begin
        sz_v         = $signed({19'b0, slot_r.size_end}) + (prod_sz_r >>> 16);
        size_res_nxt = sz_v[23:0];
        for (int c = 0; c < 3; c++) begin
          e_c  = slot_r.color_end[24-8*c +: 8];
          ch_v = $signed({19'b0, e_c}) + (prod_ch_r[c] >>> 16);
          rgb_nxt[16-8*c +: 8] = ch_v[7:0];
        end
        e_c            = slot_r.color_end[7:0];
        ch_v           = $signed({19'b0, e_c}) + (prod_ch_r[3] >>> 16);
        alpha_prod_nxt = 26'(ch_v[8:0]) * 26'(f_r);
        state_nxt      = ppe_pkg::ST_OUT;
      end
      ppe_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.draw_x     = slot_r.pos_x;
          out_nxt.draw_y     = slot_r.pos_y;
          out_nxt.draw_size  = size_res_r;
          out_nxt.draw_angle = slot_r.angle;
          out_nxt.draw_color = {rgb_r, alpha_prod_r[23:16]};
          // last when no live slot lies above this one
          out_nxt.last       = ((alive_r >> (idx_r + 1'b1)) == '0);
          out_valid_nxt      = 1'b1;
          idx_nxt            = idx_r + 1'b1;
          state_nxt          = ppe_pkg::ST_SCAN;
        end
      end
      default: state_nxt = ppe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppe_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      jit_vx_r    <= '0;
      jit_vy_r    <= '0;
      jit_sz_r    <= '0;
      alive_r     <= '0;
      next_slot_r <= AW'(POOL_SIZE - 1);
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      jit_vx_r    <= jit_vx_nxt;
      jit_vy_r    <= jit_vy_nxt;
      jit_sz_r    <= jit_sz_nxt;
      alive_r     <= alive_nxt;
      next_slot_r <= next_slot_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r         <= in_nxt;
    slot_r       <= slot_nxt;
    out_r        <= out_nxt;
    dang_r       <= dang_nxt;
    em_jx_r      <= em_jx_nxt;
    em_jy_r      <= em_jy_nxt;
    em_js_r      <= em_js_nxt;
    em_ang_r     <= em_ang_nxt;
    prod_x_r     <= prod_x_nxt;
    prod_y_r     <= prod_y_nxt;
    f_r          <= f_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    prod_sz_r    <= prod_sz_nxt;
    prod_ch_r    <= prod_ch_nxt;
    size_res_r   <= size_res_nxt;
    rgb_r        <= rgb_nxt;
    alpha_prod_r <= alpha_prod_nxt;
  end

endmodule
